/* src/hrp_pkg.sv */
// Shared types, constants and character-class functions for the HTTP request parser.
// Used by hrp_step and http_request_header_parser_core; depends on nothing else.
package hrp_pkg;

    typedef enum logic [2:0] {
        PH_METHOD    = 3'd0,
        PH_PATH      = 3'd1,
        PH_VSEARCH   = 3'd2,
        PH_VDIGIT    = 3'd3,
        PH_LINEEND   = 3'd4,
        PH_NAME      = 3'd5,
        PH_VALUE     = 3'd6,
        PH_LINESTART = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        V_RUN    = 2'd0,
        V_ACCEPT = 2'd1,
        V_REJECT = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        K_NONE    = 3'd0,
        K_METHOD  = 3'd1,
        K_PATH    = 3'd2,
        K_VERSION = 3'd3,
        K_NAME    = 3'd4,
        K_VALUE   = 3'd5
    } t_kind;

    typedef struct packed {
        t_phase     phase;
        logic       skip;
        logic       pend_cr;
        logic [1:0] esc_phase;
        logic [3:0] esc_hi;
        logic [2:0] head_cnt;
        logic       head_miss;
        t_verdict   verdict;
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       done;
        t_verdict   status;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase: PH_METHOD, skip: 1'b0, pend_cr: 1'b0, esc_phase: 2'd0,
        esc_hi: 4'd0, head_cnt: 3'd0, head_miss: 1'b0, verdict: V_RUN
    };

    localparam logic [7:0] C_SP      = 8'h20;
    localparam logic [7:0] C_CR      = 8'h0d;
    localparam logic [7:0] C_LF      = 8'h0a;
    localparam logic [7:0] C_PERCENT = 8'h25;
    localparam logic [7:0] C_PLUS    = 8'h2b;
    localparam logic [7:0] C_COLON   = 8'h3a;
    localparam logic [7:0] C_DOT     = 8'h2e;
    localparam logic [7:0] C_DASH    = 8'h2d;

    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    function automatic logic [7:0] head_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h48;
            2'd1:    c = 8'h45;
            2'd2:    c = 8'h41;
            default: c = 8'h44;
        endcase
        return c;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h41:8'h5a], [8'h61:8'h7a]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    // Letters a-f and A-F have low nibble 1..6, so adding nine gives 10..15.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return is_digit(c) ? c[3:0] : 4'(c[3:0] + 4'd9);
    endfunction

    function automatic logic is_url_sym(input logic [7:0] c);
        return is_alnum(c) ||
               (c inside {8'h2e, 8'h2f, 8'h3f, 8'h26, 8'h3d, 8'h5f, 8'h2d});
    endfunction

endpackage

/* src/hrp_step.sv */
// Per-byte parse step: next parser state and the result item for one input byte.
// Purely combinational; depends on hrp_pkg.
module hrp_step (
    input  hrp_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output hrp_pkg::t_state  o_state,
    output hrp_pkg::t_result o_res
);

    hrp_pkg::t_state n_state;
    hrp_pkg::t_kind  n_kind;
    logic [7:0]      n_char;
    logic            n_done;
    logic            n_rej;
    logic            n_name;

    always_comb begin
        n_state = i_state;
        n_kind  = hrp_pkg::K_NONE;
        n_char  = 8'd0;
        n_done  = 1'b0;
        n_rej   = 1'b0;
        n_name  = 1'b0;

        if (i_state.verdict == hrp_pkg::V_ACCEPT) begin
            if (!i_state.skip) begin
                n_state.verdict = hrp_pkg::V_REJECT;
            end
        end else if (i_state.verdict == hrp_pkg::V_RUN) begin
            case (i_state.phase)
                hrp_pkg::PH_METHOD: begin
                    if (hrp_pkg::is_alpha(i_byte)) begin
                        n_kind = hrp_pkg::K_METHOD;
                        n_char = i_byte;
                        if (!i_state.head_miss && !i_state.head_cnt[2] &&
                            i_byte == hrp_pkg::head_char(i_state.head_cnt[1:0])) begin
                            n_state.head_cnt = 3'(i_state.head_cnt + 3'd1);
                        end else begin
                            n_state.head_miss = 1'b1;
                        end
                    end else if (i_byte == hrp_pkg::C_SP) begin
                        n_kind        = hrp_pkg::K_METHOD;
                        n_done        = 1'b1;
                        n_state.phase = hrp_pkg::PH_PATH;
                        n_state.skip  = 1'b1;
                    end else begin
                        n_rej = 1'b1;
                    end
                end
                hrp_pkg::PH_PATH: begin
                    if (!(i_state.skip && i_byte == hrp_pkg::C_SP)) begin
                        n_state.skip = 1'b0;
                        if (i_state.esc_phase != hrp_pkg::ESC_IDLE) begin
                            if (!hrp_pkg::is_hex(i_byte)) begin
                                n_rej = 1'b1;
                            end else if (i_state.esc_phase == hrp_pkg::ESC_HIGH) begin
                                n_state.esc_hi    = hrp_pkg::hex_val(i_byte);
                                n_state.esc_phase = hrp_pkg::ESC_LOW;
                            end else begin
                                n_kind            = hrp_pkg::K_PATH;
                                n_char            = {i_state.esc_hi, hrp_pkg::hex_val(i_byte)};
                                n_state.esc_phase = hrp_pkg::ESC_IDLE;
                            end
                        end else if (hrp_pkg::is_url_sym(i_byte)) begin
                            n_kind = hrp_pkg::K_PATH;
                            n_char = i_byte;
                        end else if (i_byte == hrp_pkg::C_PERCENT) begin
                            n_state.esc_phase = hrp_pkg::ESC_HIGH;
                        end else if (i_byte == hrp_pkg::C_PLUS) begin
                            n_kind = hrp_pkg::K_PATH;
                            n_char = hrp_pkg::C_SP;
                        end else if (i_byte == hrp_pkg::C_SP) begin
                            n_kind        = hrp_pkg::K_PATH;
                            n_done        = 1'b1;
                            n_state.phase = hrp_pkg::PH_VSEARCH;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end
                end
                hrp_pkg::PH_VSEARCH: begin
                    if (i_byte == hrp_pkg::C_CR || i_byte == hrp_pkg::C_LF) begin
                        n_rej = 1'b1;
                    end else if (i_byte == hrp_pkg::C_DOT) begin
                        n_state.phase = hrp_pkg::PH_VDIGIT;
                    end
                end
                hrp_pkg::PH_VDIGIT: begin
                    if (hrp_pkg::is_digit(i_byte)) begin
                        n_kind        = hrp_pkg::K_VERSION;
                        n_char        = i_byte;
                        n_done        = 1'b1;
                        n_state.phase = hrp_pkg::PH_LINEEND;
                        n_state.skip  = 1'b1;
                    end else begin
                        n_rej = 1'b1;
                    end
                end
                hrp_pkg::PH_LINEEND: begin
                    if (i_state.pend_cr) begin
                        if (i_byte == hrp_pkg::C_LF) begin
                            n_state.pend_cr = 1'b0;
                            n_state.phase   = hrp_pkg::PH_LINESTART;
                            n_state.skip    = 1'b1;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end else if (i_state.skip && i_byte == hrp_pkg::C_SP) begin
                        n_state.skip = 1'b1;
                    end else if (i_byte == hrp_pkg::C_CR) begin
                        n_state.pend_cr = 1'b1;
                        n_state.skip    = 1'b0;
                    end else begin
                        n_rej = 1'b1;
                    end
                end
                hrp_pkg::PH_NAME: begin
                    n_name = 1'b1;
                end
                hrp_pkg::PH_VALUE: begin
                    if (i_state.pend_cr) begin
                        if (i_byte == hrp_pkg::C_LF) begin
                            n_kind          = hrp_pkg::K_VALUE;
                            n_done          = 1'b1;
                            n_state.pend_cr = 1'b0;
                            n_state.phase   = hrp_pkg::PH_LINESTART;
                            n_state.skip    = 1'b0;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end else if (!(i_state.skip && i_byte == hrp_pkg::C_SP)) begin
                        n_state.skip = 1'b0;
                        if (i_byte == hrp_pkg::C_CR) begin
                            n_state.pend_cr = 1'b1;
                        end else begin
                            n_kind = hrp_pkg::K_VALUE;
                            n_char = i_byte;
                        end
                    end
                end
                default: begin
                    if (i_state.pend_cr) begin
                        if (i_byte == hrp_pkg::C_LF) begin
                            n_state.pend_cr = 1'b0;
                            n_state.verdict = hrp_pkg::V_ACCEPT;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end else if (i_byte == hrp_pkg::C_CR) begin
                        if (i_state.skip &&
                            !(i_state.head_cnt == 3'd4 && !i_state.head_miss)) begin
                            n_rej = 1'b1;
                        end else begin
                            n_state.pend_cr = 1'b1;
                        end
                    end else begin
                        n_state.skip  = 1'b0;
                        n_state.phase = hrp_pkg::PH_NAME;
                        n_name        = 1'b1;
                    end
                end
            endcase

            if (n_name) begin
                if (hrp_pkg::is_alnum(i_byte) || i_byte == hrp_pkg::C_DASH) begin
                    n_kind = hrp_pkg::K_NAME;
                    n_char = i_byte;
                end else if (i_byte == hrp_pkg::C_COLON) begin
                    n_kind        = hrp_pkg::K_NAME;
                    n_done        = 1'b1;
                    n_state.phase = hrp_pkg::PH_VALUE;
                    n_state.skip  = 1'b1;
                end else begin
                    n_rej = 1'b1;
                end
            end

            if (n_rej) begin
                n_state.verdict = hrp_pkg::V_REJECT;
                n_kind          = hrp_pkg::K_NONE;
                n_char          = 8'd0;
                n_done          = 1'b0;
            end
        end

        if (i_last && n_state.verdict == hrp_pkg::V_RUN) begin
            n_state.verdict = hrp_pkg::V_REJECT;
        end

        o_res.kind   = n_kind;
        o_res.ch     = n_char;
        o_res.done   = n_done;
        o_res.status = n_state.verdict;

        o_state = i_last ? hrp_pkg::STATE_RESET : n_state;
    end

endmodule

/* src/http_request_header_parser_core.sv */
// HTTP request header parser core: one result item per input byte.
// A result item is registered and valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the output stalls, set by the single state register.
// The output register refills in the cycle it is taken, so bytes flow without gaps.
// Synchronous active-low reset returns the parser to the method phase and empties the output.
// Depends on hrp_pkg and hrp_step.
module http_request_header_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_char, [9:8] status, [15:10] zero
    output logic        m_axis_tlast,   // field_done
    output logic [2:0]  m_axis_tuser    // [2:0] out_kind
);

    hrp_pkg::t_state  r_state;
    hrp_pkg::t_state  n_state;
    hrp_pkg::t_result n_res;
    hrp_pkg::t_result r_res;
    logic             r_out_valid;
    logic             s_fire;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    hrp_step u_step (
        .i_state (r_state),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hrp_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_res.status, r_res.ch};
    assign m_axis_tlast  = r_res.done;
    assign m_axis_tuser  = r_res.kind;

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && s_axis_tlast |=>
            r_state.phase == hrp_pkg::PH_METHOD && r_state.verdict == hrp_pkg::V_RUN)
        else $error("parser state not restarted after last byte");

    a_none_has_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == hrp_pkg::K_NONE |-> m_axis_tdata[7:0] == 8'd0)
        else $error("untagged result carries a character");

    a_reject_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && !s_axis_tlast && r_state.verdict == hrp_pkg::V_REJECT |=>
            r_state.verdict == hrp_pkg::V_REJECT)
        else $error("rejected request left the rejected verdict");

    a_escape_in_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.esc_phase != hrp_pkg::ESC_IDLE |-> r_state.phase == hrp_pkg::PH_PATH)
        else $error("hex escape pending outside the path");

    a_result_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> m_axis_tvalid)
        else $error("accepted byte produced no result item");

endmodule
